// File: hw/rtl/obbct_pkg.sv
// shared types, constants and the step program for the pair contact tracker
// used by every module of the block but the ram; no dependencies

package obbct_pkg;

  localparam int ID_BITS     = 5;
  localparam int PAIR_BITS   = 2 * ID_BITS;
  localparam int TABLE_DEPTH = 1 << PAIR_BITS;

  localparam int IN_DATA_W  = 224;
  localparam int OUT_DATA_W = 8;

  localparam int STEP_BITS = 5;
  localparam logic [STEP_BITS-1:0] STEP_LAST = 5'd27;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ENTER = 2'd1;
  localparam logic [1:0] EV_STAY  = 2'd2;
  localparam logic [1:0] EV_EXIT  = 2'd3;

  // multiplier a-side operands
  localparam logic [2:0] A_LC = 3'd0;
  localparam logic [2:0] A_LS = 3'd1;
  localparam logic [2:0] A_RC = 3'd2;
  localparam logic [2:0] A_RS = 3'd3;
  localparam logic [2:0] A_L  = 3'd4;
  localparam logic [2:0] A_R  = 3'd5;
  localparam logic [2:0] A_PM = 3'd6;
  localparam logic [2:0] A_QM = 3'd7;

  // multiplier b-side operands
  localparam logic [3:0] B_LC = 4'd0;
  localparam logic [3:0] B_LS = 4'd1;
  localparam logic [3:0] B_RC = 4'd2;
  localparam logic [3:0] B_RS = 4'd3;
  localparam logic [3:0] B_DX = 4'd4;
  localparam logic [3:0] B_DY = 4'd5;
  localparam logic [3:0] B_E0 = 4'd6;
  localparam logic [3:0] B_E1 = 4'd7;
  localparam logic [3:0] B_E2 = 4'd8;
  localparam logic [3:0] B_E3 = 4'd9;

  // where a finished sum goes
  localparam logic [2:0] D_NONE = 3'd0;
  localparam logic [2:0] D_L    = 3'd1;
  localparam logic [2:0] D_R    = 3'd2;
  localparam logic [2:0] D_P    = 3'd3;
  localparam logic [2:0] D_Q    = 3'd4;
  localparam logic [2:0] D_DIST = 3'd5;
  localparam logic [2:0] D_CMP  = 3'd6;

  typedef struct packed {
    logic [PAIR_BITS-1:0] pair_index;
    logic                 both_enabled;
    logic [23:0]          delta_x;
    logic [23:0]          delta_y;
    logic [15:0]          left_cos;
    logic [15:0]          left_sin;
    logic [23:0]          left_width;
    logic [23:0]          left_height;
    logic [15:0]          right_cos;
    logic [15:0]          right_sin;
    logic [23:0]          right_width;
    logic [23:0]          right_height;
  } item_t;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [3:0] b_sel;
    logic       neg;
    logic       first;
    logic [2:0] dst;
  } ctl_t;

  typedef struct packed {
    logic vld;
    ctl_t ctl;
  } issue_t;

  typedef struct packed {
    logic                 in_ready;
    logic                 start;
    issue_t               issue;
    logic                 clr_we;
    logic [PAIR_BITS-1:0] clr_addr;
    logic                 fin_go;
  } seq_stat_t;

  function automatic ctl_t mk(input logic [2:0] a, input logic [3:0] b,
                              input logic neg, input logic first,
                              input logic [2:0] dst);
    ctl_t c;
    c.a_sel = a;
    c.b_sel = b;
    c.neg   = neg;
    c.first = first;
    c.dst   = dst;
    return c;
  endfunction

  // dot products of the axes, then per axis: distance, reach and compare
  function automatic ctl_t ucode(input logic [STEP_BITS-1:0] step);
    ctl_t c;
    c = mk(A_LC, B_LC, 1'b0, 1'b1, D_NONE);
    case (step)
      5'd0:    c = mk(A_LC, B_LC, 1'b0, 1'b1, D_NONE);
      5'd1:    c = mk(A_LS, B_LS, 1'b0, 1'b0, D_L);
      5'd2:    c = mk(A_RC, B_RC, 1'b0, 1'b1, D_NONE);
      5'd3:    c = mk(A_RS, B_RS, 1'b0, 1'b0, D_R);
      5'd4:    c = mk(A_LC, B_RC, 1'b0, 1'b1, D_NONE);
      5'd5:    c = mk(A_LS, B_RS, 1'b0, 1'b0, D_P);
      5'd6:    c = mk(A_LS, B_RC, 1'b0, 1'b1, D_NONE);
      5'd7:    c = mk(A_LC, B_RS, 1'b1, 1'b0, D_Q);
      5'd8:    c = mk(A_LC, B_DX, 1'b0, 1'b1, D_NONE);
      5'd9:    c = mk(A_LS, B_DY, 1'b0, 1'b0, D_DIST);
      5'd10:   c = mk(A_L,  B_E0, 1'b0, 1'b1, D_NONE);
      5'd11:   c = mk(A_PM, B_E2, 1'b0, 1'b0, D_NONE);
      5'd12:   c = mk(A_QM, B_E3, 1'b0, 1'b0, D_CMP);
      5'd13:   c = mk(A_LS, B_DX, 1'b1, 1'b1, D_NONE);
      5'd14:   c = mk(A_LC, B_DY, 1'b0, 1'b0, D_DIST);
      5'd15:   c = mk(A_L,  B_E1, 1'b0, 1'b1, D_NONE);
      5'd16:   c = mk(A_QM, B_E2, 1'b0, 1'b0, D_NONE);
      5'd17:   c = mk(A_PM, B_E3, 1'b0, 1'b0, D_CMP);
      5'd18:   c = mk(A_RC, B_DX, 1'b0, 1'b1, D_NONE);
      5'd19:   c = mk(A_RS, B_DY, 1'b0, 1'b0, D_DIST);
      5'd20:   c = mk(A_PM, B_E0, 1'b0, 1'b1, D_NONE);
      5'd21:   c = mk(A_QM, B_E1, 1'b0, 1'b0, D_NONE);
      5'd22:   c = mk(A_R,  B_E2, 1'b0, 1'b0, D_CMP);
      5'd23:   c = mk(A_RS, B_DX, 1'b1, 1'b1, D_NONE);
      5'd24:   c = mk(A_RC, B_DY, 1'b0, 1'b0, D_DIST);
      5'd25:   c = mk(A_QM, B_E0, 1'b0, 1'b1, D_NONE);
      5'd26:   c = mk(A_PM, B_E1, 1'b0, 1'b0, D_NONE);
      5'd27:   c = mk(A_R,  B_E3, 1'b0, 1'b0, D_CMP);
      default: c = mk(A_LC, B_LC, 1'b0, 1'b1, D_NONE);
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/obbct_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module obbct_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/obbct_mac.sv
// shared multiply-accumulate unit: one registered 33x25 product per cycle,
// accumulator and result registers for the axis test; uses obbct_pkg

module obbct_mac (
  input  logic             clk,
  input  logic             rst_n,
  input  obbct_pkg::item_t item,
  input  obbct_pkg::issue_t issue,
  input  logic             start,
  output logic             sep
);

  import obbct_pkg::*;

  logic signed [32:0] a;
  logic signed [24:0] b;
  logic signed [57:0] prod_r;
  issue_t             ret_r;
  logic signed [58:0] acc_r;
  logic signed [58:0] base;
  logic signed [58:0] sum;
  logic        [58:0] mag;
  logic        [31:0] l_r;
  logic        [31:0] rr_r;
  logic        [31:0] pm_r;
  logic        [31:0] qm_r;
  logic        [40:0] dist_r;
  logic               sep_r;

  always_comb begin
    case (issue.ctl.a_sel)
      A_LC:    a = 33'($signed(item.left_cos));
      A_LS:    a = 33'($signed(item.left_sin));
      A_RC:    a = 33'($signed(item.right_cos));
      A_RS:    a = 33'($signed(item.right_sin));
      A_L:     a = $signed({1'b0, l_r});
      A_R:     a = $signed({1'b0, rr_r});
      A_PM:    a = $signed({1'b0, pm_r});
      A_QM:    a = $signed({1'b0, qm_r});
      default: a = '0;
    endcase
    case (issue.ctl.b_sel)
      B_LC:    b = 25'($signed(item.left_cos));
      B_LS:    b = 25'($signed(item.left_sin));
      B_RC:    b = 25'($signed(item.right_cos));
      B_RS:    b = 25'($signed(item.right_sin));
      B_DX:    b = 25'($signed(item.delta_x));
      B_DY:    b = 25'($signed(item.delta_y));
      B_E0:    b = $signed({1'b0, item.left_width});
      B_E1:    b = $signed({1'b0, item.left_height});
      B_E2:    b = $signed({1'b0, item.right_width});
      B_E3:    b = $signed({1'b0, item.right_height});
      default: b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    if (!rst_n) begin
      ret_r <= '0;
    end else begin
      ret_r <= issue;
    end
  end

  always_comb begin
    base = ret_r.ctl.first ? 59'sd0 : acc_r;
    sum  = ret_r.ctl.neg ? (base - 59'(prod_r)) : (base + 59'(prod_r));
    mag  = sum[58] ? 59'(-sum) : 59'(sum);
  end

  always_ff @(posedge clk) begin
    if (ret_r.vld) begin
      acc_r <= sum;
      case (ret_r.ctl.dst)
        D_L:     l_r    <= mag[31:0];
        D_R:     rr_r   <= mag[31:0];
        D_P:     pm_r   <= mag[31:0];
        D_Q:     qm_r   <= mag[31:0];
        D_DIST:  dist_r <= mag[40:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= 1'b0;
    end else if (start) begin
      sep_r <= 1'b0;
    end else if (ret_r.vld && ret_r.ctl.dst == D_CMP) begin
      if ({3'b0, dist_r, 15'b0} > mag) begin
        sep_r <= 1'b1;
      end
    end
  end

  assign sep = sep_r;

endmodule

// File: hw/rtl/obbct_seq.sv
// sequencer: table clearing pass, step counter over the axis program,
// drain and finish handshake; uses obbct_pkg

module obbct_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_free,
  output obbct_pkg::seq_stat_t  stat
);

  import obbct_pkg::*;

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]           st_r;
  logic [STEP_BITS-1:0] step_r;
  logic [PAIR_BITS-1:0] clr_r;
  logic                 in_fire;

  assign in_fire = in_valid && (st_r == ST_IDLE);

  always_comb begin
    stat.in_ready  = (st_r == ST_IDLE);
    stat.start     = in_fire;
    stat.issue.vld = (st_r == ST_RUN);
    stat.issue.ctl = ucode(step_r);
    stat.clr_we    = (st_r == ST_CLR);
    stat.clr_addr  = clr_r;
    stat.fin_go    = (st_r == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLR;
      step_r <= '0;
      clr_r  <= '0;
    end else begin
      unique case (st_r)
        ST_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) begin
            st_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            st_r   <= ST_RUN;
            step_r <= '0;
          end
        end
        ST_RUN: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_LAST) begin
            st_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          st_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_CLR;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/obb_pair_contact_tracker.sv
// top level of the oriented-rectangle pair contact tracker
// uses obbct_pkg, obbct_seq, obbct_mac and obbct_ram
//
// one collider pair enters on the in_ stream; one result leaves on the out_
// stream for every pair. the block runs the separating-axis test over the four
// rectangle axes on a single shared multiply-accumulate unit: 8 dot-product
// steps, then 5 steps per axis (distance and reach), 28 multiplies in all.
// a result is registered in the finish state, after the run and drain states,
// and the next item can only be taken once the sequencer is back in idle;
// in_tready is low while an item is in work.
// a 1024-bit contact table, indexed by the pair, holds whether the pair touched
// last time and turns the test into none, enter, stay or exit.
// after reset the table is cleared in a pass over all 1024 entries with in_tready low.
// the result sits in an output register; while the receiver stalls, the next
// item is accepted and worked on, and then waits for that register to free up.

module obb_pair_contact_tracker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pair_index, delta_x, delta_y, left_cos, left_sin, left_width, left_height,
  // right_cos, right_sin, right_width, right_height, zero fill
  input  logic [obbct_pkg::IN_DATA_W-1:0]    in_tdata,
  // both_enabled
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // overlapping, contact_event, zero fill
  output logic [obbct_pkg::OUT_DATA_W-1:0]   out_tdata
);

  import obbct_pkg::*;

  seq_stat_t            stat;
  item_t                item_r;
  logic                 sep;
  logic                 was;
  logic                 hit;
  logic [1:0]           ev;
  logic                 out_free;
  logic                 tab_we;
  logic [PAIR_BITS-1:0] tab_waddr;
  logic                 tab_wdata;
  logic                 out_tvalid_r;
  logic                 ovl_r;
  logic [1:0]           ev_r;

  assign out_free = !out_tvalid_r || out_tready;

  obbct_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (stat.start) begin
      item_r.pair_index   <= in_tdata[PAIR_BITS-1:0];
      item_r.both_enabled <= in_tuser;
      item_r.delta_x      <= in_tdata[33:10];
      item_r.delta_y      <= in_tdata[57:34];
      item_r.left_cos     <= in_tdata[73:58];
      item_r.left_sin     <= in_tdata[89:74];
      item_r.left_width   <= in_tdata[113:90];
      item_r.left_height  <= in_tdata[137:114];
      item_r.right_cos    <= in_tdata[153:138];
      item_r.right_sin    <= in_tdata[169:154];
      item_r.right_width  <= in_tdata[193:170];
      item_r.right_height <= in_tdata[217:194];
    end
  end

  obbct_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item_r),
    .issue (stat.issue),
    .start (stat.start),
    .sep   (sep)
  );

  always_comb begin
    hit = item_r.both_enabled && !sep;
    if (hit) begin
      ev = was ? EV_STAY : EV_ENTER;
    end else begin
      ev = was ? EV_EXIT : EV_NONE;
    end
    tab_we    = stat.clr_we || stat.fin_go;
    tab_waddr = stat.clr_we ? stat.clr_addr : item_r.pair_index;
    tab_wdata = stat.clr_we ? 1'b0 : hit;
  end

  obbct_ram #(
    .WIDTH (1),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (item_r.pair_index),
    .rdata (was)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (stat.fin_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (stat.fin_go) begin
      ovl_r <= hit;
      ev_r  <= ev;
    end
  end

  assign in_tready  = stat.in_ready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W - 3){1'b0}}, ev_r, ovl_r};

endmodule

// File: dv/obbct_pair_checker.sv
`timescale 1ns / 1ps
// pair checker: predicts overlap and contact events for the contact tracker and compares results
// depends on obbct_pkg for the item layout and the event codes

module obbct_pair_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [obbct_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [obbct_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                               fail_count,
  output int                               pending_count
);

  import obbct_pkg::*;

  typedef struct packed {
    logic       overlapping;
    logic [1:0] contact_ev;
  } pair_result_t;

  logic [TABLE_DEPTH-1:0] touched_last;
  pair_result_t           awaited_results[$];
  int                     mismatches;
  int                     results_seen;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic item_t unpack_pair(input logic [IN_DATA_W-1:0] d, input logic user);
    item_t it;
    it.pair_index   = d[9:0];
    it.both_enabled = user;
    it.delta_x      = d[33:10];
    it.delta_y      = d[57:34];
    it.left_cos     = d[73:58];
    it.left_sin     = d[89:74];
    it.left_width   = d[113:90];
    it.left_height  = d[137:114];
    it.right_cos    = d[153:138];
    it.right_sin    = d[169:154];
    it.right_width  = d[193:170];
    it.right_height = d[217:194];
    return it;
  endfunction

  // exact separating-axis test; touching counts as overlap
  function automatic logic rects_touch(input item_t it);
    longint dx, dy, proj, p, gap, reach;
    longint ax[4];
    longint ay[4];
    longint ext[4];
    int     i, k;
    dx = longint'($signed(it.delta_x));
    dy = longint'($signed(it.delta_y));
    ax[0] = longint'($signed(it.left_cos));
    ay[0] = longint'($signed(it.left_sin));
    ax[1] = -ay[0];
    ay[1] = ax[0];
    ax[2] = longint'($signed(it.right_cos));
    ay[2] = longint'($signed(it.right_sin));
    ax[3] = -ay[2];
    ay[3] = ax[2];
    ext[0] = longint'(it.left_width);
    ext[1] = longint'(it.left_height);
    ext[2] = longint'(it.right_width);
    ext[3] = longint'(it.right_height);
    for (i = 0; i < 4; i++) begin
      proj = ax[i] * dx + ay[i] * dy;
      if (proj < 0) proj = -proj;
      gap = proj << 15;
      reach = 0;
      for (k = 0; k < 4; k++) begin
        p = ax[i] * ax[k] + ay[i] * ay[k];
        if (p < 0) p = -p;
        reach += p * ext[k];
      end
      if (gap > reach) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    item_t        it;
    pair_result_t want;
    logic         hit, was;
    if (!rst_n) begin
      touched_last = '0;
      awaited_results.delete();
      mismatches = 0;
      results_seen = 0;
      pending_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected item, overlapping", int'(out_tdata[0]), 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata[0] !== want.overlapping)
            report_mismatch("overlapping", int'(out_tdata[0]), int'(want.overlapping));
          if (out_tdata[2:1] !== want.contact_ev)
            report_mismatch("contact_event", int'(out_tdata[2:1]), int'(want.contact_ev));
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        it  = unpack_pair(in_tdata, in_tuser);
        was = touched_last[it.pair_index];
        hit = it.both_enabled && rects_touch(it);
        want.overlapping = hit;
        if (hit) want.contact_ev = was ? EV_STAY : EV_ENTER;
        else     want.contact_ev = was ? EV_EXIT : EV_NONE;
        touched_last[it.pair_index] = hit;
        awaited_results = {awaited_results, want};
      end
      pending_count <= awaited_results.size();
    end
  end

endmodule

// File: dv/obb_pair_contact_tracker_tb.sv
`timescale 1ns / 1ps
// testbench top for the pair contact tracker: clock, reset, directed and random pairs
// depends on obbct_pkg, obb_pair_contact_tracker and obbct_pair_checker

module obb_pair_contact_tracker_tb;
  import obbct_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    fail_count;
  int                    pending_count;
  int                    cycle_count = 0;
  logic                  idle_on = 1'b1;

  obb_pair_contact_tracker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  obbct_pair_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else        out_tready <= !idle_on || ($urandom_range(0, 99) >= 12);
  end

  function automatic item_t mk_pair(input int idx, input int en, input int dx, input int dy,
                                    input int lc, input int ls, input int lw, input int lh,
                                    input int rc, input int rs, input int rw, input int rh);
    item_t it;
    it.pair_index   = idx[PAIR_BITS-1:0];
    it.both_enabled = en[0];
    it.delta_x      = dx[23:0];
    it.delta_y      = dy[23:0];
    it.left_cos     = lc[15:0];
    it.left_sin     = ls[15:0];
    it.left_width   = lw[23:0];
    it.left_height  = lh[23:0];
    it.right_cos    = rc[15:0];
    it.right_sin    = rs[15:0];
    it.right_width  = rw[23:0];
    it.right_height = rh[23:0];
    return it;
  endfunction

  task automatic send_pair(input item_t it);
    if (idle_on && $urandom_range(0, 99) < 12) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.both_enabled;
    in_tdata  <= {6'd0, it.right_height, it.right_width, it.right_sin, it.right_cos,
                  it.left_height, it.left_width, it.left_sin, it.left_cos,
                  it.delta_y, it.delta_x, it.pair_index};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // unit axis at a random angle, sometimes exactly axis aligned
  task automatic random_axis(output int c, output int s);
    real ang;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: begin c = 16384;  s = 0;      end
        1: begin c = 0;      s = 16384;  end
        2: begin c = -16384; s = 0;      end
        default: begin c = 0; s = -16384; end
      endcase
    end else begin
      ang = $urandom_range(0, 3599) * 6.283185307179586 / 3600.0;
      c = int'(16384.0 * $cos(ang));
      s = int'(16384.0 * $sin(ang));
    end
  endtask

  task automatic random_pair(output item_t it);
    int lc, ls, rc, rs, lw, lh, rw, rh, span, dx, dy, idx, pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      it = mk_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      random_axis(lc, ls);
      random_axis(rc, rs);
      lw = $urandom_range(0, 65535);
      lh = $urandom_range(0, 65535);
      rw = $urandom_range(0, 65535);
      rh = $urandom_range(0, 65535);
      span = (lw + lh + rw + rh) / 2 + 1;
      dx = int'($urandom_range(0, 2 * span)) - span;
      dy = int'($urandom_range(0, 2 * span)) - span;
      idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, TABLE_DEPTH - 1)
                                        : $urandom_range(0, 11);
      it = mk_pair(idx, int'(pick >= 25), dx, dy, lc, ls, lw, lh, rc, rs, rw, rh);
    end
  endtask

  initial begin
    item_t it;
    int    n;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= 1'b0;
    in_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // zero-size pair: enter, stay, then exit and none when disabled
    send_pair(mk_pair(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk_pair(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // axis aligned: exactly touching, then one step apart
    send_pair(mk_pair(1, 1, 1024, 0, 16384, 0, 1024, 1024, 16384, 0, 1024, 1024));
    send_pair(mk_pair(1, 1, 1025, 0, 16384, 0, 1024, 1024, 16384, 0, 1024, 1024));
    send_pair(mk_pair(2, 1, 0, -1024, 0, 16384, 1024, 1024, 16384, 0, 1024, 1024));
    send_pair(mk_pair(2, 1, 0, -1025, 0, 16384, 1024, 1024, 16384, 0, 1024, 1024));
    // field extremes and out-of-range axis codes
    send_pair(mk_pair(1023, 1, 24'h7fffff, 24'h800000, -32768, -32768, 24'hffffff,
                      24'hffffff, -32768, -32768, 24'hffffff, 24'hffffff));
    send_pair(mk_pair(1023, 1, 24'h800000, 24'h7fffff, -32768, -32768, 0, 0,
                      -32768, -32768, 0, 0));
    send_pair(mk_pair(1023, 1, 24'h7fffff, 24'h7fffff, 32767, 32767, 24'hffffff,
                      24'hffffff, 32767, 32767, 24'hffffff, 24'hffffff));
    send_pair(mk_pair(512, 1, 24'h800000, 24'h800000, 16384, 16384, 24'hffffff,
                      24'hffffff, 16384, -16384, 24'hffffff, 24'hffffff));
    // rotated by 45 degrees against axis aligned
    send_pair(mk_pair(3, 1, 2000, 2000, 11585, 11585, 2048, 1024, 16384, 0, 1024, 4096));
    send_pair(mk_pair(3, 1, 5000, 0, 11585, -11585, 2048, 1024, 16384, 0, 1024, 4096));
    send_pair(mk_pair(1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 200 && n < 300);
      random_pair(it);
      send_pair(it);
    end
    idle_on = 1'b1;
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
